// ===== src/nmal_pkg.sv =====
package nmal_pkg;

	localparam int FRAC_BITS       = 15;
	localparam int MAX_PIXELS_LOG2 = 24;

	localparam int LEVEL_MAX = 255;
	localparam int LEVELS    = LEVEL_MAX + 1;

	// signed component, -1.0 .. +1.0
	localparam int COMP_W = FRAC_BITS + 2;
	// holds the sum of three squared components
	localparam int SQ_W   = 2 * FRAC_BITS + 2;
	// root and quotient width
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
	// magnitude of a running sum plus rounding term
	localparam int NUM_W  = MAX_PIXELS_LOG2 + FRAC_BITS + 1;
	localparam int SUM_W  = NUM_W + 1;
	localparam int REM_W  = (SQ_W > CNT_W + 1) ? SQ_W : CNT_W + 1;
	localparam int ALU_W  = REM_W + 1;
	localparam int STEP_W = $clog2(QUO_W + 1);

	localparam logic [SQ_W-1:0]  UNIT_SQ   = {2'b01, {(2 * FRAC_BITS){1'b0}}};
	localparam logic [QUO_W-1:0] ONE_LEN   = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [CNT_W-1:0] PIXEL_LIM = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t comp_table_t [LEVELS];

	typedef enum logic {
		OP_SQRT = 1'b0,
		OP_DIV  = 1'b1
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;

	// unorm level -> round((2c - 255) * 2^F / 255), built at elaboration
	function automatic comp_table_t build_comp_table();
		comp_table_t t;
		longint      d;
		longint      mag;
		longint      q;
		for (int i = 0; i < LEVELS; i++) begin
			d   = 2 * i - LEVEL_MAX;
			mag = (d < 0) ? -d : d;
			mag = mag << FRAC_BITS;
			q   = (mag + LEVEL_MAX / 2) / LEVEL_MAX;
			t[i] = COMP_W'((d < 0) ? -q : q);
		end
		return t;
	endfunction

	localparam comp_table_t COMP_TABLE = build_comp_table();

endpackage

// ===== src/normal_map_average_length.sv =====
// Average-normal length of a two-channel normal map.
// Pixel channel: red_level, green_level, last_pixel with pixel_valid/pixel_stall.
// Each pixel is mapped to Q1.15 x and y, z is rebuilt by a square root, and
// x, y, z and a pixel count are accumulated. The pixel marked last closes the
// image: each sum is divided by the count (rounded), and the length of the
// average normal (Q1.15, saturated at 1.0) goes out with the pixel count and
// an overflow flag on the result channel (result_valid/result_stall).
// One shared iterative unit does every root and division at one bit per
// cycle under the sequencer; one multiplier squares.
// An accepted pixel holds off the next one until its pass is done (a pixel
// dropped at the count limit does not, unless it is last). Last pixel: its own
// pass, three divisions, the final root and the load of the output register
// come before result_valid.
// Results sit in an output register: a stalled receiver does not stop the
// next image from accumulating, only the next result from being written.
// Reset clears the sums, the count and any pending result.
module normal_map_average_length (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  logic [7:0]                 red_level,
	input  logic [7:0]                 green_level,
	input  logic                       last_pixel,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [nmal_pkg::QUO_W-1:0] avg_length,
	output logic [nmal_pkg::CNT_W-1:0] pixel_total,
	output logic                       count_overflow
);

	typedef enum logic [14:0] {
		S_IDLE      = 15'b000000000000001,
		S_PX_MX     = 15'b000000000000010,
		S_PX_MY     = 15'b000000000000100,
		S_PX_ADD    = 15'b000000000001000,
		S_PX_ROOT   = 15'b000000000010000,
		S_PX_WAIT   = 15'b000000000100000,
		S_DV_PREP   = 15'b000000001000000,
		S_DV_START  = 15'b000000010000000,
		S_DV_WAIT   = 15'b000000100000000,
		S_DV_MUL    = 15'b000001000000000,
		S_DV_ACC    = 15'b000010000000000,
		S_LEN_START = 15'b000100000000000,
		S_LEN_WAIT  = 15'b001000000000000,
		S_EMIT      = 15'b010000000000000,
		S_SPARE     = 15'b100000000000000
	} state_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	state_t                             state_q;
	axis_t                              axis_q;
	logic signed [nmal_pkg::SUM_W-1:0]  sum_x_q;
	logic signed [nmal_pkg::SUM_W-1:0]  sum_y_q;
	logic [nmal_pkg::NUM_W-1:0]         sum_z_q;
	logic [nmal_pkg::CNT_W-1:0]         count_q;
	logic                               dropped_q;
	logic                               res_valid_q;

	nmal_pkg::comp_t                    x_q;
	nmal_pkg::comp_t                    y_q;
	nmal_pkg::comp_t                    avg_q;
	logic                               last_q;
	logic                               neg_q;
	logic [nmal_pkg::SQ_W-1:0]          mul_q;
	logic [nmal_pkg::SQ_W-1:0]          acc_q;
	logic [nmal_pkg::NUM_W-1:0]         num_q;
	logic [nmal_pkg::QUO_W-1:0]         len_q;
	logic [nmal_pkg::QUO_W-1:0]         avg_length_q;
	logic [nmal_pkg::CNT_W-1:0]         pixel_total_q;
	logic                               count_overflow_q;

	nmal_pkg::iter_ctl_t                iter_ctl;
	nmal_pkg::iter_sts_t                iter_sts;
	logic [nmal_pkg::QUO_W-1:0]         iter_result;
	logic [nmal_pkg::SQ_W-1:0]          radicand;

	logic                               pixel_xfer;
	logic                               result_xfer;
	logic                               at_limit;
	logic                               emit;
	nmal_pkg::comp_t                    mul_op;
	logic signed [2*nmal_pkg::COMP_W-1:0] product;
	logic signed [nmal_pkg::SUM_W-1:0]  sel_sum;
	logic signed [nmal_pkg::SUM_W-1:0]  sel_mag;
	logic [nmal_pkg::COMP_W-1:0]        quo_ext;

	assign pixel_stall  = (state_q != S_IDLE);
	assign pixel_xfer   = pixel_valid && !pixel_stall;
	assign result_valid = res_valid_q;
	assign result_xfer  = res_valid_q && !result_stall;
	assign at_limit     = (count_q >= nmal_pkg::PIXEL_LIM);
	// output register free this cycle
	assign emit         = (state_q == S_EMIT) && (!res_valid_q || !result_stall);

	always_comb begin
		unique case (state_q)
			S_PX_MX: mul_op = x_q;
			S_PX_MY: mul_op = y_q;
			default: mul_op = avg_q;
		endcase
		product = mul_op * mul_op;

		case (axis_q)
			AX_X:    sel_sum = sum_x_q;
			AX_Y:    sel_sum = sum_y_q;
			default: sel_sum = $signed({1'b0, sum_z_q});
		endcase
		sel_mag = sel_sum[nmal_pkg::SUM_W-1] ? -sel_sum : sel_sum;
		quo_ext = {1'b0, iter_result};

		if (state_q == S_PX_ROOT) begin
			radicand = (acc_q >= nmal_pkg::UNIT_SQ) ? '0 : nmal_pkg::UNIT_SQ - acc_q;
		end else begin
			radicand = acc_q;
		end

		iter_ctl.start = (state_q == S_PX_ROOT) || (state_q == S_DV_START) ||
		                 (state_q == S_LEN_START);
		iter_ctl.op    = (state_q == S_DV_START) ? nmal_pkg::OP_DIV : nmal_pkg::OP_SQRT;
	end

	nmal_iter_unit u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (iter_ctl),
		.radicand (radicand),
		.numer    (num_q),
		.divisor  (count_q),
		.sts      (iter_sts),
		.result   (iter_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= AX_X;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result_xfer) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pixel_xfer) begin
						if (at_limit) begin
							dropped_q <= 1'b1;
							if (last_pixel) begin
								axis_q  <= AX_X;
								state_q <= (count_q == '0) ? S_EMIT : S_DV_PREP;
							end
						end else begin
							state_q <= S_PX_MX;
						end
					end
				end
				S_PX_MX: begin
					sum_x_q <= sum_x_q + nmal_pkg::SUM_W'(x_q);
					sum_y_q <= sum_y_q + nmal_pkg::SUM_W'(y_q);
					count_q <= count_q + 1'b1;
					state_q <= S_PX_MY;
				end
				S_PX_MY:   state_q <= S_PX_ADD;
				S_PX_ADD:  state_q <= S_PX_ROOT;
				S_PX_ROOT: state_q <= S_PX_WAIT;
				S_PX_WAIT: begin
					if (iter_sts.done) begin
						sum_z_q <= sum_z_q + nmal_pkg::NUM_W'(iter_result);
						axis_q  <= AX_X;
						state_q <= last_q ? S_DV_PREP : S_IDLE;
					end
				end
				S_DV_PREP:  state_q <= S_DV_START;
				S_DV_START: state_q <= S_DV_WAIT;
				S_DV_WAIT: begin
					if (iter_sts.done) begin
						state_q <= S_DV_MUL;
					end
				end
				S_DV_MUL: state_q <= S_DV_ACC;
				S_DV_ACC: begin
					if (axis_q == AX_Z) begin
						state_q <= S_LEN_START;
					end else begin
						axis_q  <= (axis_q == AX_X) ? AX_Y : AX_Z;
						state_q <= S_DV_PREP;
					end
				end
				S_LEN_START: state_q <= S_LEN_WAIT;
				S_LEN_WAIT: begin
					if (iter_sts.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						sum_z_q     <= '0;
						count_q     <= '0;
						dropped_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_xfer) begin
			x_q    <= nmal_pkg::COMP_TABLE[red_level];
			y_q    <= nmal_pkg::COMP_TABLE[green_level];
			last_q <= last_pixel;
			// empty image reads as a unit normal
			len_q  <= nmal_pkg::ONE_LEN;
		end
		if (state_q == S_PX_MX || state_q == S_PX_MY || state_q == S_DV_MUL) begin
			mul_q <= product[nmal_pkg::SQ_W-1:0];
		end
		if (state_q == S_PX_MY) begin
			acc_q <= mul_q;
		end else if (state_q == S_PX_ADD || state_q == S_DV_ACC) begin
			acc_q <= acc_q + mul_q;
		end else if (state_q == S_DV_PREP && axis_q == AX_X) begin
			acc_q <= '0;
		end
		if (state_q == S_DV_PREP) begin
			neg_q <= sel_sum[nmal_pkg::SUM_W-1];
			num_q <= sel_mag[nmal_pkg::NUM_W-1:0] + nmal_pkg::NUM_W'(count_q >> 1);
		end
		if (state_q == S_DV_WAIT && iter_sts.done) begin
			avg_q <= neg_q ? -quo_ext : quo_ext;
		end
		if (state_q == S_LEN_WAIT && iter_sts.done) begin
			len_q <= (iter_result > nmal_pkg::ONE_LEN) ? nmal_pkg::ONE_LEN : iter_result;
		end
		if (emit) begin
			avg_length_q     <= len_q;
			pixel_total_q    <= count_q;
			count_overflow_q <= dropped_q;
		end
	end

	assign avg_length     = avg_length_q;
	assign pixel_total    = pixel_total_q;
	assign count_overflow = count_overflow_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= nmal_pkg::PIXEL_LIM)
		else $error("pixel count past limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		dropped_q |-> count_q == nmal_pkg::PIXEL_LIM)
		else $error("drop flagged below the count limit");
	assert property (@(posedge clk) disable iff (!arst_n)
		iter_sts.done |-> (state_q == S_PX_WAIT || state_q == S_DV_WAIT ||
		                   state_q == S_LEN_WAIT))
		else $error("iter unit finished outside a wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result_valid && count_q == '0 && !dropped_q)
		else $error("result written without clearing the image state");

endmodule

// ===== src/nmal_iter_unit.sv =====
// Shared restoring unit: integer square root or integer division,
// one compare/subtract per cycle.
module nmal_iter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nmal_pkg::iter_ctl_t        ctl,
	input  logic [nmal_pkg::SQ_W-1:0]  radicand,
	input  logic [nmal_pkg::NUM_W-1:0] numer,
	input  logic [nmal_pkg::CNT_W-1:0] divisor,
	output nmal_pkg::iter_sts_t        sts,
	output logic [nmal_pkg::QUO_W-1:0] result
);

	nmal_pkg::iter_op_t               op_q;
	logic                             busy_q;
	logic                             done_q;
	logic [nmal_pkg::STEP_W-1:0]      step_q;
	logic [nmal_pkg::REM_W-1:0]       rem_q;
	logic [nmal_pkg::REM_W-1:0]       root_q;
	logic [nmal_pkg::SQ_W-1:0]        bit_q;
	logic [nmal_pkg::CNT_W-1:0]       dvs_q;

	logic [nmal_pkg::CNT_W:0]         trial;
	logic [nmal_pkg::ALU_W-1:0]       alu_a;
	logic [nmal_pkg::ALU_W-1:0]       alu_b;
	logic [nmal_pkg::ALU_W-1:0]       diff;
	logic                             take;

	always_comb begin
		trial = {rem_q[nmal_pkg::CNT_W-1:0], bit_q[nmal_pkg::QUO_W-1]};
		if (op_q == nmal_pkg::OP_SQRT) begin
			// root and bit never overlap, so OR is the add
			alu_a = nmal_pkg::ALU_W'(rem_q);
			alu_b = nmal_pkg::ALU_W'(root_q | nmal_pkg::REM_W'(bit_q));
		end else begin
			alu_a = nmal_pkg::ALU_W'(trial);
			alu_b = nmal_pkg::ALU_W'(dvs_q);
		end
		diff = alu_a - alu_b;
		take = !diff[nmal_pkg::ALU_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			op_q   <= nmal_pkg::OP_SQRT;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				op_q   <= ctl.op;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == nmal_pkg::STEP_W'(nmal_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			root_q <= '0;
			dvs_q  <= divisor;
			if (ctl.op == nmal_pkg::OP_SQRT) begin
				rem_q <= nmal_pkg::REM_W'(radicand);
				bit_q <= {2'b01, {(nmal_pkg::SQ_W - 2){1'b0}}};
			end else begin
				// high part is already below the divisor: quotient fits QUO_W bits
				rem_q <= nmal_pkg::REM_W'(numer[nmal_pkg::NUM_W-1:nmal_pkg::QUO_W]);
				bit_q <= nmal_pkg::SQ_W'(numer[nmal_pkg::QUO_W-1:0]);
			end
		end else if (busy_q) begin
			if (op_q == nmal_pkg::OP_SQRT) begin
				if (take) begin
					rem_q  <= diff[nmal_pkg::REM_W-1:0];
					root_q <= (root_q >> 1) | nmal_pkg::REM_W'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				rem_q  <= nmal_pkg::REM_W'(take ? diff[nmal_pkg::CNT_W:0] : trial);
				root_q <= {root_q[nmal_pkg::REM_W-2:0], take};
				bit_q  <= bit_q << 1;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = root_q[nmal_pkg::QUO_W-1:0];

	assert property (@(posedge clk) disable iff (!arst_n) ctl.start |-> !busy_q)
		else $error("iter unit restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q) && !busy_q)
		else $error("iter unit done without a running operation");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && op_q == nmal_pkg::OP_DIV) |-> rem_q[nmal_pkg::CNT_W-1:0] < dvs_q)
		else $error("partial remainder not below divisor");
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> root_q[nmal_pkg::REM_W-1:nmal_pkg::QUO_W] == '0)
		else $error("iter unit result overflows");

endmodule

// ===== verif/avg_length_checker.sv =====
`timescale 1ns / 1ps

module avg_length_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pixel_valid,
	input  logic                       pixel_stall,
	input  logic [7:0]                 red_level,
	input  logic [7:0]                 green_level,
	input  logic                       last_pixel,
	input  logic                       result_valid,
	input  logic                       result_stall,
	input  logic [nmal_pkg::QUO_W-1:0] avg_length,
	input  logic [nmal_pkg::CNT_W-1:0] pixel_total,
	input  logic                       count_overflow,
	output int                         mismatch_count,
	output int                         images_open,
	output int                         images_checked
);

	typedef struct {
		logic [nmal_pkg::QUO_W-1:0] length;
		logic [nmal_pkg::CNT_W-1:0] total;
		logic                       dropped;
	} image_summary_t;

	image_summary_t closed_images[$];

	// running image state
	longint          run_x;
	longint          run_y;
	longint          run_z;
	longint          run_count;
	logic            run_dropped;
	int              errors;
	int              checked;

	// unorm level -> signed Q.F component, -1.0 .. +1.0
	function automatic longint level_to_comp(input logic [7:0] level);
		longint d;
		longint mag;
		d   = 2 * longint'(level) - nmal_pkg::LEVEL_MAX;
		mag = ((d < 0) ? -d : d) << nmal_pkg::FRAC_BITS;
		mag = (mag + nmal_pkg::LEVEL_MAX / 2) / nmal_pkg::LEVEL_MAX;
		return (d < 0) ? -mag : mag;
	endfunction

	function automatic longint root_floor(input longint v);
		longint r;
		longint b;
		longint rem;
		rem = v;
		r   = 0;
		b   = longint'(1) << 62;
		while (b > rem)
			b = b >> 2;
		while (b != 0) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// rounded to nearest, halves away from zero
	function automatic longint mean_of(input longint s, input longint n);
		longint mag;
		longint q;
		mag = (s < 0) ? -s : s;
		q   = (mag + n / 2) / n;
		return (s < 0) ? -q : q;
	endfunction

	task automatic clear_image();
		run_x       = 0;
		run_y       = 0;
		run_z       = 0;
		run_count   = 0;
		run_dropped = 1'b0;
	endtask

	task automatic absorb_pixel(input logic [7:0] r, input logic [7:0] g, input logic fin);
		longint         x;
		longint         y;
		longint         sq;
		longint         unit;
		longint         one;
		longint         ax;
		longint         ay;
		longint         az;
		longint         len;
		image_summary_t s;
		x    = level_to_comp(r);
		y    = level_to_comp(g);
		one  = longint'(1) << nmal_pkg::FRAC_BITS;
		unit = one * one;
		if (run_count >= (longint'(1) << nmal_pkg::MAX_PIXELS_LOG2)) begin
			run_dropped = 1'b1;
		end else begin
			sq    = x * x + y * y;
			run_x = run_x + x;
			run_y = run_y + y;
			if (sq < unit)
				run_z = run_z + root_floor(unit - sq);
			run_count = run_count + 1;
		end
		if (fin) begin
			if (run_count == 0) begin
				len = one;
			end else begin
				ax  = mean_of(run_x, run_count);
				ay  = mean_of(run_y, run_count);
				az  = mean_of(run_z, run_count);
				len = root_floor(ax * ax + ay * ay + az * az);
				if (len > one)
					len = one;
			end
			s.length  = nmal_pkg::QUO_W'(len);
			s.total   = nmal_pkg::CNT_W'(run_count);
			s.dropped = run_dropped;
			closed_images.insert(closed_images.size(), s);
			clear_image();
		end
	endtask

	task automatic compare_result();
		image_summary_t e;
		if (closed_images.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected result: avg_length %0d pixel_total %0d overflow %0b",
					$time, avg_length, pixel_total, count_overflow);
		end else begin
			e = closed_images.pop_front();
			checked++;
			if (avg_length !== e.length || pixel_total !== e.total ||
				count_overflow !== e.dropped) begin
				errors++;
				if (errors <= 10)
					$display("%0t: image %0d exp/got: length %0d/%0d %s",
						$time, checked, e.length, avg_length,
						$sformatf("total %0d/%0d overflow %0b/%0b",
							e.total, pixel_total, e.dropped, count_overflow));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_image();
			closed_images.delete();
			errors         = 0;
			checked        = 0;
			mismatch_count <= 0;
			images_open    <= 0;
			images_checked <= 0;
		end else begin
			// older image leaves before a new one may close
			if (result_valid && !result_stall)
				compare_result();
			if (pixel_valid && !pixel_stall)
				absorb_pixel(red_level, green_level, last_pixel);
			mismatch_count <= errors;
			images_open    <= closed_images.size();
			images_checked <= checked;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	typedef enum {MIX_UNIFORM, MIX_SMOOTH, MIX_EXTREME} pixel_mix_t;

	localparam int PIXEL_TARGET   = 1450;
	localparam int QUIET_TAIL     = 150;
	localparam int SQUEEZE_AT     = 300;
	localparam int SQUEEZE_CYCLES = 800;
	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 150;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       pixel_valid;
	logic                       pixel_stall;
	logic [7:0]                 red_level;
	logic [7:0]                 green_level;
	logic                       last_pixel;
	logic                       result_valid;
	logic                       result_stall;
	logic [nmal_pkg::QUO_W-1:0] avg_length;
	logic [nmal_pkg::CNT_W-1:0] pixel_total;
	logic                       count_overflow;

	int   mismatch_count;
	int   images_open;
	int   images_checked;
	int   pixels_sent;
	int   images_sent;
	int   dead_cycles = 0;
	logic quiet;
	logic squeeze_req;
	logic squeeze_done;

	always #6 clk = ~clk;

	normal_map_average_length dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.red_level      (red_level),
		.green_level    (green_level),
		.last_pixel     (last_pixel),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.avg_length     (avg_length),
		.pixel_total    (pixel_total),
		.count_overflow (count_overflow)
	);

	avg_length_checker u_length_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.red_level      (red_level),
		.green_level    (green_level),
		.last_pixel     (last_pixel),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.avg_length     (avg_length),
		.pixel_total    (pixel_total),
		.count_overflow (count_overflow),
		.mismatch_count (mismatch_count),
		.images_open    (images_open),
		.images_checked (images_checked)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
				dead_cycles <= 0;
			end else if (dead_cycles >= STALL_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d images open",
					dead_cycles, images_open);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				dead_cycles <= dead_cycles + 1;
			end
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic fin);
		pixel_valid <= 1'b1;
		red_level   <= r;
		green_level <= g;
		last_pixel  <= fin;
		do @(posedge clk); while (pixel_stall);
		pixels_sent++;
		if (fin)
			images_sent++;
		if (pixels_sent >= PIXEL_TARGET - QUIET_TAIL)
			quiet = 1'b1;
		if (pixels_sent >= SQUEEZE_AT)
			squeeze_req = 1'b1;
	endtask

	function automatic logic [7:0] pick_level(input pixel_mix_t mix);
		case (mix)
			MIX_SMOOTH: return 8'($urandom_range(108, 148));
			MIX_EXTREME: begin
				case ($urandom_range(0, 5))
					0: return 8'd0;
					1: return 8'd1;
					2: return 8'd127;
					3: return 8'd128;
					4: return 8'd254;
					default: return 8'd255;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_image(input int n, input pixel_mix_t mix, input int gap_pct);
		for (int i = 0; i < n; i++) begin
			// sender keeps offering while the output side is held off
			if (!quiet && !(squeeze_req && !squeeze_done) &&
				$urandom_range(0, 99) < gap_pct) begin
				pixel_valid <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			send_pixel(pick_level(mix), pick_level(mix), i == n - 1);
		end
	endtask

	// output side: random stall bursts, one long hold-off
	initial begin
		int stall_pct;
		int span;
		result_stall = 1'b0;
		squeeze_done = 1'b0;
		stall_pct    = 0;
		span         = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (span == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 30;
				endcase
				span = 150;
			end
			span--;
			if (squeeze_req && !squeeze_done) begin
				result_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
				squeeze_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		int         image_px;
		int         gap_pct;
		pixel_mix_t mix;
		arst_n      = 1'b0;
		pixel_valid = 1'b0;
		red_level   = 8'd0;
		green_level = 8'd0;
		last_pixel  = 1'b0;
		quiet       = 1'b0;
		squeeze_req = 1'b0;
		pixels_sent = 0;
		images_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-pixel images: corners saturate, center is near flat
		send_pixel(8'd0, 8'd0, 1'b1);
		send_pixel(8'd255, 8'd255, 1'b1);
		send_pixel(8'd255, 8'd0, 1'b1);
		send_pixel(8'd0, 8'd255, 1'b1);
		send_pixel(8'd128, 8'd128, 1'b1);
		send_pixel(8'd127, 8'd127, 1'b1);
		// opposite tilts cancel, short average
		send_pixel(8'd0, 8'd128, 1'b0);
		send_pixel(8'd255, 8'd128, 1'b1);
		send_pixel(8'd0, 8'd127, 1'b0);
		send_pixel(8'd255, 8'd127, 1'b0);
		send_pixel(8'd127, 8'd0, 1'b0);
		send_pixel(8'd127, 8'd255, 1'b1);
		send_pixel(8'd1, 8'd254, 1'b0);
		send_pixel(8'd254, 8'd1, 1'b0);
		send_pixel(8'd128, 8'd127, 1'b0);
		send_pixel(8'd127, 8'd128, 1'b0);
		send_pixel(8'd128, 8'd128, 1'b0);
		send_pixel(8'd200, 8'd60, 1'b1);

		while (pixels_sent < PIXEL_TARGET) begin
			case ($urandom_range(0, 19))
				0: image_px = $urandom_range(41, 120);
				1, 2, 3, 4, 5: image_px = $urandom_range(13, 40);
				default: image_px = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 3))
				0: mix = MIX_UNIFORM;
				1: mix = MIX_EXTREME;
				default: mix = MIX_SMOOTH;
			endcase
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 10;
				default: gap_pct = 35;
			endcase
			send_image(image_px, mix, gap_pct);
		end
		pixel_valid <= 1'b0;

		do @(posedge clk); while (images_open != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels in %0d images; %0d averages compared.",
			pixels_sent, images_sent, images_checked);
		$display("Mix of smooth, uniform and extreme levels, with a long output hold-off.");
		if (mismatch_count == 0 && images_open == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
